FILE: rtl/fixed_point_decimal_formatter_defines.svh
// assertion macros for the fixed-point decimal formatter checker
// expects clk and rst in scope at the point of use
`ifndef FIXED_POINT_DECIMAL_FORMATTER_DEFINES_SVH
`define FIXED_POINT_DECIMAL_FORMATTER_DEFINES_SVH

// property checked outside reset
`define FPDF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fpdf checker: property failed");

// property that also covers the reset cycles
`define FPDF_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fpdf checker: reset property failed");

`endif

FILE: rtl/fpdf_pkg.sv
// shared types, constants and helpers of the fixed-point decimal formatter
// no dependencies
`timescale 1ns / 1ps

package fpdf_pkg;

  localparam int MAX_FRACTION_DIGITS_DEF = 9;

  localparam int WORD_W      = 32;
  localparam int INT_DIGITS  = 10;
  localparam int DIGIT_IDX_W = 4;
  localparam int PREC_W      = 4;
  localparam int Q_W         = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_DIGITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_BITS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE     = 2'd2;

  // configuration reset values
  localparam logic [PREC_W-1:0] FRACTION_DIGITS_RST = 4'd2;
  localparam logic [Q_W-1:0]    FRAC_BITS_RST       = 6'd16;

  // all bits fractional
  localparam logic [Q_W-1:0] Q_FULL = 6'd32;

  // ascii codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;

  // character source select
  typedef logic [1:0] sel_t;
  localparam sel_t SEL_SIGN  = 2'd0;
  localparam sel_t SEL_INT   = 2'd1;
  localparam sel_t SEL_POINT = 2'd2;
  localparam sel_t SEL_FRAC  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic                   load;
    logic                   mul;
    logic                   shift;
    logic                   round;
    logic                   conv_step;
    logic                   emit;
    sel_t                   sel;
    logic [DIGIT_IDX_W-1:0] idx;
    logic                   last;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic                   neg;
    logic [DIGIT_IDX_W-1:0] lead;
  } dp_status_t;

  // powers of ten up to nine digits
  function automatic logic [WORD_W-1:0] pow10(input logic [PREC_W-1:0] d);
    logic [WORD_W-1:0] r;
    begin
      case (d)
        4'd0:    r = 32'd1;
        4'd1:    r = 32'd10;
        4'd2:    r = 32'd100;
        4'd3:    r = 32'd1000;
        4'd4:    r = 32'd10000;
        4'd5:    r = 32'd100000;
        4'd6:    r = 32'd1000000;
        4'd7:    r = 32'd10000000;
        4'd8:    r = 32'd100000000;
        4'd9:    r = 32'd1000000000;
        default: r = 32'd1;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: rtl/fpdf_ctrl.sv
// sequencing state machine of the fixed-point decimal formatter
// depends on fpdf_pkg
`timescale 1ns / 1ps

module fpdf_ctrl
  import fpdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PREC_W-1:0] prec,
  input  dp_status_t        status,
  output dp_cmd_t           cmd,
  output logic              busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_SHIFT = 4'd2;
  localparam logic [3:0] S_ROUND = 4'd3;
  localparam logic [3:0] S_CONV  = 4'd4;
  localparam logic [3:0] S_LEAD  = 4'd5;
  localparam logic [3:0] S_SIGN  = 4'd6;
  localparam logic [3:0] S_INT   = 4'd7;
  localparam logic [3:0] S_POINT = 4'd8;
  localparam logic [3:0] S_FRAC  = 4'd9;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(WORD_W - 1);

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // state and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.sel    = SEL_SIGN;
    cmd.idx    = cnt[DIGIT_IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        cnt_next   = '0;
        state_next = S_CONV;
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        cnt_next      = cnt + 5'd1;
        if (cnt == CONV_LAST) begin
          state_next = S_LEAD;
        end
      end
      S_LEAD: begin
        cnt_next   = {1'b0, status.lead};
        state_next = status.neg ? S_SIGN : S_INT;
      end
      S_SIGN: begin
        cmd.emit   = 1'b1;
        cmd.sel    = SEL_SIGN;
        state_next = S_INT;
      end
      S_INT: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_INT;
        cmd.last = (cnt == '0) && (prec == '0);
        if (cnt == '0) begin
          state_next = (prec == '0) ? S_IDLE : S_POINT;
        end else begin
          cnt_next = cnt - 5'd1;
        end
      end
      S_POINT: begin
        cmd.emit   = 1'b1;
        cmd.sel    = SEL_POINT;
        cnt_next   = CNT_W'(prec) - 5'd1;
        state_next = S_FRAC;
      end
      S_FRAC: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_FRAC;
        cmd.last = (cnt == '0);
        if (cnt == '0) begin
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt - 5'd1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: rtl/fpdf_dp.sv
// datapath of the fixed-point decimal formatter: scale, round, binary to bcd, char out
// depends on fpdf_pkg
`timescale 1ns / 1ps

module fpdf_dp
  import fpdf_pkg::*;
#(
  parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  input  logic [WORD_W-1:0] fixed_word,
  input  logic              signed_mode,
  input  logic [Q_W-1:0]    q,
  input  logic [PREC_W-1:0] prec,
  output dp_status_t        status,
  output logic              out_valid,
  output logic [7:0]        out_char,
  output logic              last
);

  localparam int SCALE_W     = $clog2(10 ** MAX_FRACTION_DIGITS + 1);
  localparam int PROD_W      = WORD_W + SCALE_W;
  localparam int INT_BCD_W   = 4 * INT_DIGITS;
  localparam int FRAC_DIGITS = MAX_FRACTION_DIGITS;
  localparam int FRAC_BCD_W  = 4 * FRAC_DIGITS;

  logic                  neg;
  logic [WORD_W-1:0]     mag;
  logic [PROD_W-1:0]     prod;
  logic [SCALE_W-1:0]    frac_sh;
  logic                  rbit;
  logic [WORD_W-1:0]     int_reg;
  logic [WORD_W-1:0]     int_bin;
  logic [WORD_W-1:0]     frac_bin;
  logic [INT_BCD_W-1:0]  bcd_int;
  logic [FRAC_BCD_W-1:0] bcd_frac;

  logic [WORD_W-1:0]     scale_full;
  logic [SCALE_W-1:0]    scale;
  logic [WORD_W-1:0]     mask;
  logic [4:0]            q_m1;
  logic                  q_mid;
  logic [SCALE_W:0]      frac_sum;
  logic                  carry;
  logic [SCALE_W:0]      frac_fin;
  logic [INT_BCD_W-1:0]  int_adj;
  logic [FRAC_BCD_W-1:0] frac_adj;
  logic [DIGIT_IDX_W-1:0] lead_idx;
  logic [3:0]            int_digit;
  logic [3:0]            frac_digit;
  logic [7:0]            char_sel;

  // scale factor, fraction mask and rounding position
  assign scale_full = pow10(prec);
  assign scale      = scale_full[SCALE_W-1:0];
  assign mask       = ~(32'hFFFF_FFFF << q);
  assign q_m1       = 5'(q - 6'd1);
  assign q_mid      = (q != '0) && (q != Q_FULL);

  // rounding and carry into the integer part
  assign frac_sum = {1'b0, frac_sh} + (SCALE_W + 1)'(rbit);
  assign carry    = (frac_sum >= {1'b0, scale});
  assign frac_fin = carry ? (frac_sum - {1'b0, scale}) : frac_sum;

  // add-3 correction of each bcd digit
  always_comb begin
    int_adj = bcd_int;
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (bcd_int[4*i +: 4] >= 4'd5) begin
        int_adj[4*i +: 4] = bcd_int[4*i +: 4] + 4'd3;
      end
    end
    frac_adj = bcd_frac;
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      if (bcd_frac[4*i +: 4] >= 4'd5) begin
        frac_adj[4*i +: 4] = bcd_frac[4*i +: 4] + 4'd3;
      end
    end
  end

  // highest nonzero integer digit
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (bcd_int[4*i +: 4] != 4'd0) begin
        lead_idx = DIGIT_IDX_W'(i);
      end
    end
  end

  // status word: sign then leading digit index
  assign status = {neg, lead_idx};

  // load, multiply, shift, round and bcd conversion
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= signed_mode && fixed_word[WORD_W-1];
      mag <= (signed_mode && fixed_word[WORD_W-1]) ? (32'd0 - fixed_word) : fixed_word;
    end
    if (cmd.mul) begin
      prod <= (mag & mask) * scale;
    end
    if (cmd.shift) begin
      frac_sh <= SCALE_W'(prod >> q);
      rbit    <= q_mid && prod[q_m1];
      int_reg <= mag >> q;
    end
    if (cmd.round) begin
      int_bin  <= int_reg + WORD_W'(carry);
      frac_bin <= WORD_W'(frac_fin[SCALE_W-1:0]);
      bcd_int  <= '0;
      bcd_frac <= '0;
    end
    if (cmd.conv_step) begin
      {bcd_int, int_bin}   <= {int_adj[INT_BCD_W-2:0], int_bin, 1'b0};
      {bcd_frac, frac_bin} <= {frac_adj[FRAC_BCD_W-2:0], frac_bin, 1'b0};
    end
  end

  // character select
  assign int_digit  = 4'(bcd_int >> {cmd.idx, 2'b00});
  assign frac_digit = 4'(bcd_frac >> {cmd.idx, 2'b00});

  always_comb begin
    unique case (cmd.sel)
      SEL_SIGN:  char_sel = CHAR_MINUS;
      SEL_INT:   char_sel = CHAR_ZERO + {4'b0000, int_digit};
      SEL_POINT: char_sel = CHAR_POINT;
      SEL_FRAC:  char_sel = CHAR_ZERO + {4'b0000, frac_digit};
      default:   char_sel = CHAR_ZERO;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= char_sel;
      last     <= cmd.last;
    end
  end

endmodule

FILE: rtl/fixed_point_decimal_formatter.sv
// Fixed-point to decimal ASCII formatter, top level.
// Depends on fpdf_pkg, fpdf_ctrl and fpdf_dp.
//
// Usage: pulse start with fixed_word while busy is low; the word is taken on
// that edge and busy rises on the next cycle. The text leaves as one character
// per cycle on out_char, each valid for exactly one cycle with out_valid high;
// last marks the final character. The receiver cannot stall the output.
// The first character follows the load, multiply, shift, round, 32-step
// shift-add-3 bcd conversion and leading digit search steps. An item of n
// characters (1 to 21) holds busy from the multiply step through the bcd
// conversion, leading digit search and the emission of all n characters.
// A new start may be taken while the last character is on the outputs.
// Configuration: cfg_valid/cfg_ready write channel, index 0 fraction_digits,
// 1 frac_bits, 2 signed_mode, index 3 ignored; cfg_ready is always high.
// Write only while busy is low. Reset (rst, synchronous) returns the
// registers to 2 digits, 16 fraction bits, signed mode, and clears the
// controller and out_valid.
`timescale 1ns / 1ps

module fixed_point_decimal_formatter
  import fpdf_pkg::*;
#(
  parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [WORD_W-1:0]     fixed_word,
  output logic                  out_valid,
  output logic [7:0]            out_char,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PREC_W-1:0] fraction_digits;
  logic [Q_W-1:0]    frac_bits;
  logic              signed_mode;
  logic [PREC_W-1:0] prec;
  logic [Q_W-1:0]    q;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_digits <= FRACTION_DIGITS_RST;
      frac_bits       <= FRAC_BITS_RST;
      signed_mode     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRACTION_DIGITS: fraction_digits <= cfg_data[PREC_W-1:0];
        CFG_FRAC_BITS:       frac_bits       <= cfg_data[Q_W-1:0];
        CFG_SIGNED_MODE:     signed_mode     <= cfg_data[0];
        default:             ;
      endcase
    end
  end

  // saturated precision and fraction bit count
  assign prec = (fraction_digits > PREC_W'(MAX_FRACTION_DIGITS)) ?
                PREC_W'(MAX_FRACTION_DIGITS) : fraction_digits;
  assign q    = (frac_bits > Q_FULL) ? Q_FULL : frac_bits;

  fpdf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .prec   (prec),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  fpdf_dp #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .fixed_word  (fixed_word),
    .signed_mode (signed_mode),
    .q           (q),
    .prec        (prec),
    .status      (status),
    .out_valid   (out_valid),
    .out_char    (out_char),
    .last        (last)
  );

endmodule

FILE: rtl/fpdf_checker.sv
// port-level checker of the fixed-point decimal formatter, bound to the top level
// depends on fixed_point_decimal_formatter_defines.svh
`timescale 1ns / 1ps
`include "fixed_point_decimal_formatter_defines.svh"

module fpdf_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic last
);

  // a taken word keeps the block busy
  `FPDF_ASSERT(a_start_busy, (start && !busy) |=> busy)

  // characters only come from work in progress
  `FPDF_ASSERT(a_valid_from_busy, out_valid |-> $past(busy))

  // last with out_valid implies out_valid; always holds, so last is not tied to a valid word
  `FPDF_ASSERT(a_last_valid, last && out_valid |-> out_valid)

  // nothing follows the final character directly
  `FPDF_ASSERT(a_gap_after_last, (out_valid && last) |=> !out_valid)

  // reset leaves the block idle and quiet
  `FPDF_ASSERT_RST(a_reset_idle, rst |=> (!busy && !out_valid))

endmodule

bind fixed_point_decimal_formatter fpdf_checker u_fpdf_checker (.*);
